### src/grl_pkg.sv
// ---------------------------------------------------------------------------
// grl_pkg: shared types and constants of the ranged random number block
// Request and result layouts, the command passed from the front end to the
// back end, status codes and the generator constants.
// ---------------------------------------------------------------------------
package grl_pkg;

  localparam logic [31:0] TAP_MASK   = 32'hd000_0001;
  localparam logic [31:0] SEED_RESET = 32'h2345_6789;
  localparam int          DIV_STEPS  = 32;
  localparam int          DIV_CNT_W  = 5;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_RAW   = 2'd1,
    KIND_BOUND = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SEED = 2'd1,
    ST_BAD_BOUND = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_KEEP     = 3'd1,
    OP_ADV_ZERO = 3'd2,
    OP_ADV_ADD  = 3'd3,
    OP_ADV_MOD  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SHIFT = 2'd1,
    BK_DIV   = 2'd2,
    BK_WRITE = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [31:0]        seed_value;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [31:0] operand;
    logic [31:0] offset;
  } cmd_t;

endpackage

### src/galois_lfsr_ranged_random.sv
// ---------------------------------------------------------------------------
// galois_lfsr_ranged_random: ranged random number generator
// A 32-bit Galois LFSR seed with load, raw, bounded and ranged draws.
//
//   channel  ports                         direction
//   request  in_push, in_full, in_item     in
//   result   out_empty, out_pop, out_item  out
//
// A load goes straight to the result write. A raw or rejected draw first
// shifts the seed SHIFTS_PER_DRAW times, one shift a cycle, and a bounded
// or ranged draw then runs the back end's one-bit-a-cycle remainder loop.
// Reset sets the seed to 0x23456789 and empties both queues.
// A two-entry command queue and the result register let requests be taken
// while a result is still waiting to be popped.
// ---------------------------------------------------------------------------
module galois_lfsr_ranged_random #(
  parameter int SHIFTS_PER_DRAW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  grl_pkg::in_t  in_item,
  output logic          out_empty,
  input  logic          out_pop,
  output grl_pkg::out_t out_item
);

  grl_pkg::cmd_t push_cmd;
  grl_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  grl_front u_front (
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  grl_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_cmd),
    .empty    (q_empty)
  );

  grl_back #(
    .SHIFTS_PER_DRAW (SHIFTS_PER_DRAW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### src/grl_front.sv
// ---------------------------------------------------------------------------
// grl_front: request decoder
// Checks each request and turns it into a command for the back end.
// ---------------------------------------------------------------------------
module grl_front (
  input  logic         in_push,
  input  grl_pkg::in_t in_item,
  output logic         in_full,
  input  logic         q_full,
  output logic         q_push,
  output grl_pkg::cmd_t q_cmd
);

  logic [31:0] span;
  logic        range_bad;

  assign span      = 32'(in_item.second_value - in_item.first_value + 32'sd1);
  assign range_bad = in_item.second_value < in_item.first_value;
  assign in_full   = q_full;
  assign q_push    = in_push && !q_full;

  always_comb begin
    q_cmd.op      = grl_pkg::OP_ADV_ADD;
    q_cmd.status  = grl_pkg::ST_OK;
    q_cmd.operand = 32'd0;
    q_cmd.offset  = 32'd0;
    unique case (grl_pkg::kind_t'(in_item.kind))
      grl_pkg::KIND_LOAD: begin
        if (in_item.first_value == 32'sd0) begin
          q_cmd.op     = grl_pkg::OP_KEEP;
          q_cmd.status = grl_pkg::ST_ZERO_SEED;
        end else begin
          q_cmd.op      = grl_pkg::OP_LOAD;
          q_cmd.operand = in_item.first_value;
        end
      end
      grl_pkg::KIND_RAW: begin
        q_cmd.op = grl_pkg::OP_ADV_ADD;
      end
      grl_pkg::KIND_BOUND: begin
        if (in_item.first_value <= 32'sd0) begin
          q_cmd.op     = grl_pkg::OP_ADV_ZERO;
          q_cmd.status = grl_pkg::ST_BAD_BOUND;
        end else begin
          q_cmd.op      = grl_pkg::OP_ADV_MOD;
          q_cmd.operand = in_item.first_value;
        end
      end
      grl_pkg::KIND_RANGE: begin
        if (range_bad) begin
          q_cmd.op     = grl_pkg::OP_ADV_ZERO;
          q_cmd.status = grl_pkg::ST_BAD_RANGE;
        end else if (span == 32'd0) begin
          q_cmd.op     = grl_pkg::OP_ADV_ADD;
          q_cmd.offset = in_item.first_value;
        end else begin
          q_cmd.op      = grl_pkg::OP_ADV_MOD;
          q_cmd.operand = span;
          q_cmd.offset  = in_item.first_value;
        end
      end
      default: begin
        q_cmd.op = grl_pkg::OP_ADV_ADD;
      end
    endcase
  end

endmodule

### src/grl_cmdq.sv
// ---------------------------------------------------------------------------
// grl_cmdq: command queue
// Two-entry queue between the request decoder and the back end.
// ---------------------------------------------------------------------------
module grl_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  grl_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output grl_pkg::cmd_t head,
  output logic          empty
);

  localparam int DEPTH = 2;

  grl_pkg::cmd_t entry_r [DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = count_r == 2'(DEPTH);
  assign empty = count_r == 2'd0;
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### src/grl_back.sv
// ---------------------------------------------------------------------------
// grl_back: generator and reduction engine
// Holds the seed, advances it one shift a cycle, reduces it with a
// bit-serial restoring divider and writes the result register.
// ---------------------------------------------------------------------------
module grl_back #(
  parameter int SHIFTS_PER_DRAW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  grl_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output grl_pkg::out_t out_item
);

  localparam int CNT_W = $clog2(SHIFTS_PER_DRAW + 1);

  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    lfsr_step = (s >> 1) ^ ({32{s[0]}} & grl_pkg::TAP_MASK);
  endfunction

  grl_pkg::back_state_t state_r, state_nxt;
  grl_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [31:0]          seed_r, seed_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     scnt_r, scnt_nxt;
  logic [grl_pkg::DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  grl_pkg::out_t        out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [32:0]          trial;
  logic [33:0]          diff;
  logic [31:0]          stepped;

  assign stepped   = lfsr_step(seed_r);
  assign trial     = {rem_r, dvd_r[31]};
  assign diff      = {1'b0, trial} - {2'b00, cmd_r.operand};
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grl_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.op == grl_pkg::OP_LOAD || q_head.op == grl_pkg::OP_KEEP) begin
            state_nxt = grl_pkg::BK_WRITE;
          end else begin
            state_nxt = grl_pkg::BK_SHIFT;
          end
        end
      end
      grl_pkg::BK_SHIFT: begin
        if (scnt_r == '0) begin
          state_nxt = (cmd_r.op == grl_pkg::OP_ADV_MOD) ? grl_pkg::BK_DIV
                                                          : grl_pkg::BK_WRITE;
        end
      end
      grl_pkg::BK_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = grl_pkg::BK_WRITE;
        end
      end
      grl_pkg::BK_WRITE: begin
        if (out_load) begin
          state_nxt = grl_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = grl_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = (state_r == grl_pkg::BK_IDLE) && !q_empty;
    out_load = (state_r == grl_pkg::BK_WRITE) && (!out_valid_r || out_pop);
  end

  always_comb begin
    cmd_nxt       = q_pop ? q_head : cmd_r;
    seed_nxt      = seed_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    scnt_nxt      = scnt_r;
    dcnt_nxt      = dcnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;

    if (q_pop) begin
      scnt_nxt = CNT_W'(SHIFTS_PER_DRAW - 1);
    end

    if (state_r == grl_pkg::BK_SHIFT) begin
      seed_nxt = stepped;
      scnt_nxt = scnt_r - 1'b1;
      rem_nxt  = 32'd0;
      dvd_nxt  = stepped;
      dcnt_nxt = grl_pkg::DIV_CNT_W'(grl_pkg::DIV_STEPS - 1);
    end

    if (state_r == grl_pkg::BK_DIV) begin
      rem_nxt  = diff[33] ? trial[31:0] : diff[31:0];
      dvd_nxt  = {dvd_r[30:0], 1'b0};
      dcnt_nxt = dcnt_r - 1'b1;
    end

    if (out_load) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = cmd_r.status;
      out_nxt.seed_value = seed_r;
      case (cmd_r.op)
        grl_pkg::OP_LOAD: begin
          seed_nxt           = cmd_r.operand;
          out_nxt.seed_value = cmd_r.operand;
          out_nxt.result_value = cmd_r.operand;
        end
        grl_pkg::OP_ADV_ADD: begin
          out_nxt.result_value = seed_r + cmd_r.offset;
        end
        grl_pkg::OP_ADV_MOD: begin
          out_nxt.result_value = rem_r + cmd_r.offset;
        end
        default: begin
          out_nxt.result_value = 32'sd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grl_pkg::BK_IDLE;
      seed_r      <= grl_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    scnt_r <= scnt_nxt;
    dcnt_r <= dcnt_nxt;
    out_r  <= out_nxt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench of the ranged random number generator
// A directed table covers seed loads (including a refused zero seed), raw
// draws, bounds at and beyond their limits and ranges from a single value
// up to the full 32-bit span. Random requests follow in phases of sender
// idling and receiver stalls, then a long receiver hold-off and a sender
// pause. Every result is compared with a predictor that keeps its own copy
// of the LFSR seed; typed table rows give their own expected value and status.
// ---------------------------------------------------------------------------
module tb;

  localparam int SHIFTS         = 32;
  localparam int PHASE_REQUESTS = 130;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct packed {
    grl_pkg::in_t    req;
    logic            typed;
    logic [31:0]     want_value;
    grl_pkg::status_t want_status;
  } directed_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_push;
  logic          in_full;
  grl_pkg::in_t  in_item;
  logic          out_empty;
  logic          out_pop;
  grl_pkg::out_t out_item;

  logic [31:0]   model_seed = grl_pkg::SEED_RESET;
  grl_pkg::out_t pending_draws[$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  bit            hold_request = 1'b0;

  int idle_plan[4]  = '{0, 50, 0, 7};
  int stall_plan[4] = '{0, 0, 50, 7};

  directed_row_t directed_rows[DIRECTED_ROWS] = '{
    '{'{grl_pkg::KIND_RAW,   32'h0000_0000, 32'h0000_0000},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_LOAD,  32'h0000_0001, 32'h0000_0000},
      1'b1, 32'h0000_0001, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RAW,   32'hffff_ffff, 32'hffff_ffff},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_LOAD,  32'h0000_0000, 32'h0000_0000},
      1'b1, 32'h0000_0000, grl_pkg::ST_ZERO_SEED},
    '{'{grl_pkg::KIND_LOAD,  32'hffff_ffff, 32'h0000_0000},
      1'b1, 32'hffff_ffff, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RAW,   32'h0000_0000, 32'h0000_0000},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_LOAD,  32'h8000_0000, 32'h0000_0000},
      1'b1, 32'h8000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_BOUND, 32'h0000_0001, 32'hffff_ffff},
      1'b1, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_BOUND, 32'h7fff_ffff, 32'h0000_0000},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_BOUND, 32'h0000_0000, 32'h0000_0000},
      1'b1, 32'h0000_0000, grl_pkg::ST_BAD_BOUND},
    '{'{grl_pkg::KIND_BOUND, 32'hffff_ffff, 32'h0000_0000},
      1'b1, 32'h0000_0000, grl_pkg::ST_BAD_BOUND},
    '{'{grl_pkg::KIND_BOUND, 32'h8000_0000, 32'h0000_0000},
      1'b1, 32'h0000_0000, grl_pkg::ST_BAD_BOUND},
    '{'{grl_pkg::KIND_RANGE, 32'h8000_0000, 32'h7fff_ffff},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h0000_0005, 32'h0000_0005},
      1'b1, 32'h0000_0005, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h0000_0006, 32'h0000_0005},
      1'b1, 32'h0000_0000, grl_pkg::ST_BAD_RANGE},
    '{'{grl_pkg::KIND_RANGE, 32'h7fff_ffff, 32'h8000_0000},
      1'b1, 32'h0000_0000, grl_pkg::ST_BAD_RANGE},
    '{'{grl_pkg::KIND_RANGE, 32'hffff_fff6, 32'h0000_000a},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h8000_0000, 32'h8000_0000},
      1'b1, 32'h8000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h7fff_ffff, 32'h7fff_ffff},
      1'b1, 32'h7fff_ffff, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h8000_0000, 32'hffff_ffff},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h0000_0000, 32'h7fff_ffff},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RANGE, 32'h8000_0001, 32'h7fff_ffff},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_LOAD,  32'h2345_6789, 32'h0000_0000},
      1'b1, 32'h2345_6789, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_BOUND, 32'h0000_0007, 32'h0000_0000},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK},
    '{'{grl_pkg::KIND_RAW,   32'h1234_5678, 32'h9abc_def0},
      1'b0, 32'h0000_0000, grl_pkg::ST_OK}
  };

  galois_lfsr_ranged_random u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic grl_pkg::out_t predict_draw(grl_pkg::in_t req);
    grl_pkg::out_t draw;
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [31:0]   span;
    draw.result_value = '0;
    draw.status       = grl_pkg::ST_OK;
    lo = req.first_value;
    hi = req.second_value;
    if (grl_pkg::kind_t'(req.kind) == grl_pkg::KIND_LOAD) begin
      if (lo != 32'd0) begin
        model_seed        = lo;
        draw.result_value = lo;
      end else begin
        draw.status = grl_pkg::ST_ZERO_SEED;
      end
    end else begin
      for (int i = 0; i < SHIFTS; i++) begin
        model_seed = (model_seed >> 1) ^ (model_seed[0] ? grl_pkg::TAP_MASK : 32'd0);
      end
      case (grl_pkg::kind_t'(req.kind))
        grl_pkg::KIND_RAW: begin
          draw.result_value = model_seed;
        end
        grl_pkg::KIND_BOUND: begin
          if (lo == 32'd0 || lo[31]) draw.status = grl_pkg::ST_BAD_BOUND;
          else draw.result_value = model_seed % lo;
        end
        default: begin
          if ($signed(hi) < $signed(lo)) begin
            draw.status = grl_pkg::ST_BAD_RANGE;
          end else begin
            span = hi - lo + 32'd1;
            if (span == 32'd0) draw.result_value = model_seed + lo;
            else draw.result_value = (model_seed % span) + lo;
          end
        end
      endcase
    end
    draw.seed_value = model_seed;
    return draw;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'($urandom_range(20));
      1: return 32'd0 - 32'($urandom_range(20));
      2: return {1'b0, 31'($urandom())};
      3: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic grl_pkg::in_t random_request();
    grl_pkg::in_t req;
    logic [31:0]  lo;
    logic [31:0]  hi;
    logic [31:0]  near;
    req.kind         = 2'($urandom_range(3));
    req.first_value  = pick_value();
    req.second_value = pick_value();
    case (grl_pkg::kind_t'(req.kind))
      grl_pkg::KIND_LOAD: begin
        if ($urandom_range(19) == 0) req.first_value = '0;
      end
      grl_pkg::KIND_BOUND: begin
        if ($urandom_range(9) < 8 && (req.first_value <= 0)) begin
          req.first_value = $urandom_range(3) == 0 ? {1'b0, 31'($urandom())} :
                            32'($urandom_range(1000, 1));
          if (req.first_value == 0) req.first_value = 32'd1;
        end
      end
      grl_pkg::KIND_RANGE: begin
        lo = req.first_value;
        hi = req.second_value;
        if ($urandom_range(2) == 0) begin
          near = lo + 32'($urandom_range(50));
          if ($signed(near) >= $signed(lo)) hi = near;
        end
        if ($urandom_range(9) < 8 && $signed(hi) < $signed(lo)) begin
          near = lo;
          lo   = hi;
          hi   = near;
        end
        if ($urandom_range(24) == 0) begin
          lo = 32'h8000_0000;
          hi = 32'h7fff_ffff;
        end
        req.first_value  = lo;
        req.second_value = hi;
      end
      default: ;
    endcase
    return req;
  endfunction

  task automatic send_request(grl_pkg::in_t req, logic typed,
                              logic [31:0] want_value,
                              grl_pkg::status_t want_status);
    grl_pkg::out_t draw;
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
    draw = predict_draw(req);
    if (typed) begin
      draw.result_value = want_value;
      draw.status       = want_status;
    end
    pending_draws.push_back(draw);
  endtask

  // Receiver side: random pop stalls, or one long hold-off on request.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    grl_pkg::out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_draws.size() == 0) begin
        $error("result with no request outstanding: result_value %0d seed_value %h",
               out_item.result_value, out_item.seed_value);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        if (out_item.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d", want.result_value,
                 out_item.result_value);
          mismatches++;
        end
        if (out_item.seed_value !== want.seed_value) begin
          $error("seed_value: expected %h, actual %h", want.seed_value, out_item.seed_value);
          mismatches++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          mismatches++;
        end
      end
    end
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[galois_lfsr_ranged_random] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].want_value, directed_rows[i].want_status);
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      repeat (PHASE_REQUESTS) send_request(random_request(), 1'b0, '0, grl_pkg::ST_OK);
    end

    // The receiver holds off while requests keep coming, so the input backs up.
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    repeat (40) send_request(random_request(), 1'b0, '0, grl_pkg::ST_OK);

    // The sender waits until every outstanding request has been answered.
    in_push <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    stall_pct = 20;
    repeat (30) send_request(random_request(), 1'b0, '0, grl_pkg::ST_OK);

    in_push <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[galois_lfsr_ranged_random] OK");
    end else begin
      $display("[galois_lfsr_ranged_random] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/grl_pkg.sv
src/grl_front.sv
src/grl_cmdq.sv
src/grl_back.sv
src/galois_lfsr_ranged_random.sv
tb/tb.sv
